// ===== src/i2p_pkg.sv =====
// Shared types, codes and helpers for the infix to postfix converter.
package i2p_pkg;

  // Token codes on both channels
  typedef enum logic [2:0] {
    KIND_OPERAND = 3'd0,
    KIND_PLUS    = 3'd1,
    KIND_MINUS   = 3'd2,
    KIND_TIMES   = 3'd3,
    KIND_DIVIDE  = 3'd4,
    KIND_OPEN    = 3'd5,
    KIND_CLOSE   = 3'd6
  } kind_t;

  // Result code that carries flags only (shares its code with open on the stack)
  localparam kind_t KIND_MARKER = KIND_OPEN;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CLOSE    = 2'd1,
    ERR_OPEN     = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_OP,
    ST_POP_CLOSE,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit_in;
    logic push;
    logic pop;
    logic emit_top;
    logic set_err;
    err_t err_code;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t in_kind;
    logic  in_last;
    logic  last;
    logic  cnt_zero;
    logic  cnt_full;
    logic  top_open;
    logic  top_binds;
    logic  pend_valid;
    logic  slot_free;
  } status_t;

  // Binding strength of an operator; zero for anything else
  function automatic logic [1:0] prec(input kind_t k);
    logic [1:0] p;
    unique case (k) inside
      KIND_PLUS, KIND_MINUS:  p = 2'd1;
      KIND_TIMES, KIND_DIVIDE: p = 2'd2;
      default:                p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== src/i2p_tok_if.sv =====
// Input token channel: valid/ready handshake with the token payload.
interface i2p_tok_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             kind;
  logic [VALUE_WIDTH-1:0] operand_value;
  logic                   last;

  modport source (output valid, output kind, output operand_value, output last, input ready);
  modport sink   (input valid, input kind, input operand_value, input last, output ready);
endinterface

// ===== src/i2p_res_if.sv =====
// Result channel: valid/ready handshake with one postfix result.
interface i2p_res_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             out_kind;
  logic [VALUE_WIDTH-1:0] out_value;
  logic                   end_of_expression;
  logic [1:0]             error_code;

  modport source (output valid, output out_kind, output out_value,
                  output end_of_expression, output error_code, input ready);
  modport sink   (input valid, input out_kind, input out_value,
                  input end_of_expression, input error_code, output ready);
endinterface

// ===== src/infix_to_postfix_converter_core.sv =====
// A result is held pending and moves to the output register when the next one is made or
// its token finishes. An operand, open paren or ignored code is loaded in idle, then
// finished. An operator pops each stacked operator that binds at least as tightly, then is
// pushed; a close paren pops operators up to its open paren. A last token flushes the stack.
// Tokens are taken one at a time, with one stack pop per cycle while results can move on.
// Reset (rst_n low, synchronous) empties the stack and drops any pending result.
module infix_to_postfix_converter_core
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  i2p_tok_if.sink   in_tok,
  i2p_res_if.source out_res
);

  cmd_t    cmd;
  status_t st;
  logic    ctrl_in_ready;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tok.valid),
    .in_ready (ctrl_in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_tok.kind),
    .in_operand_value (in_tok.operand_value),
    .in_last          (in_tok.last),
    .out_valid        (out_res.valid),
    .out_ready        (out_res.ready),
    .out_kind         (out_res.out_kind),
    .out_value        (out_res.out_value),
    .out_end          (out_res.end_of_expression),
    .out_err          (out_res.error_code),
    .cmd              (cmd),
    .st               (st)
  );

  assign in_tok.ready = ctrl_in_ready;

endmodule

// ===== src/i2p_ctrl.sv =====
// Controller: sequences load, pop, push, flush and finish for one token.
module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   go;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new result may only be made when the pending one can move on
  assign go       = st.slot_free || !st.pend_valid;
  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.err_code = ERR_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (st.in_kind) inside
            KIND_OPERAND: begin
              cmd.emit_in = 1'b1;
              state_nxt   = st.in_last ? ST_FLUSH : ST_FINISH;
            end
            KIND_OPEN: begin
              if (st.cnt_full) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ERR_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
              state_nxt = st.in_last ? ST_FLUSH : ST_FINISH;
            end
            KIND_PLUS, KIND_MINUS, KIND_TIMES, KIND_DIVIDE: begin
              state_nxt = ST_POP_OP;
            end
            KIND_CLOSE: begin
              state_nxt = ST_POP_CLOSE;
            end
            default: begin
              state_nxt = st.in_last ? ST_FLUSH : ST_FINISH;
            end
          endcase
        end
      end
      ST_POP_OP: begin
        if (go) begin
          if (!st.cnt_zero && !st.top_open && st.top_binds) begin
            cmd.pop      = 1'b1;
            cmd.emit_top = 1'b1;
          end else begin
            if (st.cnt_full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ERR_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
            state_nxt = st.last ? ST_FLUSH : ST_FINISH;
          end
        end
      end
      ST_POP_CLOSE: begin
        if (go) begin
          if (st.cnt_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ERR_CLOSE;
            state_nxt    = st.last ? ST_FLUSH : ST_FINISH;
          end else begin
            cmd.pop = 1'b1;
            if (st.top_open) begin
              state_nxt = st.last ? ST_FLUSH : ST_FINISH;
            end else begin
              cmd.emit_top = 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (go) begin
          if (st.cnt_zero) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.pop = 1'b1;
            if (st.top_open) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ERR_OPEN;
            end else begin
              cmd.emit_top = 1'b1;
            end
          end
        end
      end
      ST_FINISH: begin
        if (st.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // Tokens are only taken with nothing left pending from the previous one
  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !st.pend_valid)
    else $error("token loaded with a result still pending");

  // Finishing a token always returns to idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == ST_IDLE))
    else $error("finish did not return to idle");

  // Never pop an empty stack
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !st.cnt_zero)
    else $error("pop from empty stack");
`endif

endmodule

// ===== src/i2p_datapath.sv =====
// Datapath: token registers, operator stack, pending result and output register.
module i2p_datapath
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [2:0]             in_kind,
  input  logic [VALUE_WIDTH-1:0] in_operand_value,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_kind,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic                   out_end,
  output logic [1:0]             out_err,
  input  cmd_t                   cmd,
  output status_t                st
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Stack storage; top_r mirrors the top entry, rd_r the one below it
  logic [2:0] stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, rd_cnt;
  kind_t top_r, rd_r, push_kind;

  // Current token
  kind_t kind_r;
  logic  last_r;
  err_t  err_r, err_nxt;

  // Pending result (not yet known to be the final one)
  logic                   pend_valid_r;
  kind_t                  pend_kind_r;
  logic [VALUE_WIDTH-1:0] pend_value_r;

  // Output register
  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic                   out_end_r;
  err_t                   out_err_r;

  logic slot_free;
  logic move_pend;
  logic move_marker;

  assign slot_free = !out_valid_r || out_ready;
  assign push_kind = cmd.load ? kind_t'(in_kind) : kind_r;

  // Next stack count and read address for the entry below the new top
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end
  assign rd_cnt = cnt_nxt - CNT_W'(2);

  // Write on push, read the entry under the next top
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[cnt_r[IDX_W-1:0]] <= push_kind;
    end
    rd_r <= kind_t'(stack_mem[rd_cnt[IDX_W-1:0]]);
  end

  // Advance the count and top copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_r <= push_kind;
    end else if (cmd.pop) begin
      top_r <= rd_r;
    end
  end

  // Error register keeps the first error found for the token
  always_comb begin
    err_nxt = err_r;
    if (cmd.load) begin
      err_nxt = cmd.set_err ? cmd.err_code : ERR_NONE;
    end else if (cmd.set_err && (err_r == ERR_NONE)) begin
      err_nxt = cmd.err_code;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    if (cmd.load) begin
      kind_r <= kind_t'(in_kind);
      last_r <= in_last;
    end
  end

  // Pending result: fill on emit, drain on finish
  assign move_pend   = (cmd.emit_top || cmd.finish) && pend_valid_r;
  assign move_marker = cmd.finish && !pend_valid_r && (last_r || (err_r != ERR_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.emit_in || cmd.emit_top) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.finish) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_in) begin
      pend_kind_r  <= KIND_OPERAND;
      pend_value_r <= in_operand_value;
    end else if (cmd.emit_top) begin
      pend_kind_r  <= top_r;
      pend_value_r <= '0;
    end
  end

  // Output register: load on a move, clear on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move_pend || move_marker) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_pend) begin
      out_kind_r  <= pend_kind_r;
      out_value_r <= pend_value_r;
      out_end_r   <= cmd.finish && last_r;
      out_err_r   <= cmd.finish ? err_r : ERR_NONE;
    end else if (move_marker) begin
      out_kind_r  <= KIND_MARKER;
      out_value_r <= '0;
      out_end_r   <= last_r;
      out_err_r   <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_end   = out_end_r;
  assign out_err   = out_err_r;

  // Status back to the controller
  always_comb begin
    st            = '0;
    st.in_kind    = kind_t'(in_kind);
    st.in_last    = in_last;
    st.last       = last_r;
    st.cnt_zero   = (cnt_r == '0);
    st.cnt_full   = (cnt_r >= CNT_W'(STACK_DEPTH));
    st.top_open   = (top_r == KIND_OPEN);
    st.top_binds  = (prec(top_r) >= prec(kind_r));
    st.pend_valid = pend_valid_r;
    st.slot_free  = slot_free;
  end

`ifndef ASSERT_OFF
  // The count never passes the stack depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // Never push onto a full stack
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (cnt_r < CNT_W'(STACK_DEPTH)))
    else $error("push onto full stack");

  // A result only enters the output register when it is free
  a_out_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (move_pend || move_marker) |-> slot_free)
    else $error("output register overwritten before transfer");
`endif

endmodule

// ===== tb/infix_to_postfix_converter_core_test.sv =====
// Testbench for the infix to postfix converter core: stimulus, prediction and checking.
`timescale 1ns / 100ps

module infix_to_postfix_converter_core_test
  import i2p_pkg::*;
();

  localparam int STACK_DEPTH  = 16;
  localparam int VALUE_WIDTH  = 32;
  localparam int RESET_CYCLES = 12;
  localparam int ITEM_TARGET  = 270;
  localparam int CALM_FROM    = 150;
  localparam int CALM_TO      = 200;
  localparam int HOLD_AT      = 90;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 9;

  // Token code that the block ignores
  localparam logic [2:0] KIND_UNDEF = 3'd7;

  typedef struct packed {
    logic [2:0]             kind;
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
  } token_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [VALUE_WIDTH-1:0] value;
    logic                   eoe;
    err_t                   err;
  } postfix_t;

  // Operator-stack model and store of expected postfix tokens
  class postfix_board;
    logic [2:0] op_stack[STACK_DEPTH];
    int         depth_used;
    postfix_t   want_q[$];
    int         fails;

    function new();
      depth_used = 0;
      fails = 0;
    endfunction

    function int unsigned binding_rank(logic [2:0] k);
      case (k) inside
        KIND_PLUS, KIND_MINUS:   return 1;
        KIND_TIMES, KIND_DIVIDE: return 2;
        default:                 return 0;
      endcase
    endfunction

    function void add_result(logic [2:0] k, logic [VALUE_WIDTH-1:0] v);
      postfix_t r;
      r.kind  = k;
      r.value = (k == KIND_OPERAND) ? v : '0;
      r.eoe   = 1'b0;
      r.err   = ERR_NONE;
      want_q.push_back(r);
    endfunction

    // Advance the stack model by one accepted token and queue its results
    function void note_token(token_t t);
      int         first;
      err_t       err;
      logic       found;
      logic [2:0] top;
      first = want_q.size();
      err = ERR_NONE;
      case (t.kind) inside
        KIND_OPERAND: add_result(KIND_OPERAND, t.value);
        KIND_PLUS, KIND_MINUS, KIND_TIMES, KIND_DIVIDE: begin
          while (depth_used > 0 && op_stack[depth_used-1] != KIND_OPEN &&
                 binding_rank(op_stack[depth_used-1]) >= binding_rank(t.kind)) begin
            depth_used--;
            add_result(op_stack[depth_used], '0);
          end
          if (depth_used >= STACK_DEPTH) begin
            err = ERR_OVERFLOW;
          end else begin
            op_stack[depth_used] = t.kind;
            depth_used++;
          end
        end
        KIND_OPEN: begin
          if (depth_used >= STACK_DEPTH) begin
            err = ERR_OVERFLOW;
          end else begin
            op_stack[depth_used] = KIND_OPEN;
            depth_used++;
          end
        end
        KIND_CLOSE: begin
          found = 1'b0;
          while (depth_used > 0 && !found) begin
            depth_used--;
            top = op_stack[depth_used];
            if (top == KIND_OPEN) found = 1'b1;
            else add_result(top, '0);
          end
          if (!found) err = ERR_CLOSE;
        end
        default: ;
      endcase
      // Flush the stack on the final token, dropping stray opens
      if (t.last) begin
        while (depth_used > 0) begin
          depth_used--;
          top = op_stack[depth_used];
          if (top == KIND_OPEN) begin
            if (err == ERR_NONE) err = ERR_OPEN;
          end else begin
            add_result(top, '0);
          end
        end
      end
      if (want_q.size() == first && (t.last || err != ERR_NONE))
        add_result(KIND_MARKER, '0);
      if (want_q.size() > first) begin
        want_q[want_q.size()-1].eoe = t.last;
        want_q[want_q.size()-1].err = err;
      end
    endfunction

    function void report(string msg);
      fails++;
      if (fails <= 10) $display("%s", msg);
    endfunction

    // Compare one transfer on the result channel with the oldest expectation
    function void check_result(postfix_t got);
      postfix_t want;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected result: kind %0d value %h eoe %0d err %0d",
                         got.kind, got.value, got.eoe, got.err));
        return;
      end
      want = want_q.pop_front();
      if (got.kind !== want.kind || got.value !== want.value ||
          got.eoe !== want.eoe || got.err !== want.err)
        report($sformatf({"mismatch: expected kind %0d value %h eoe %0d err %0d,",
                          " got kind %0d value %h eoe %0d err %0d"},
                         want.kind, want.value, want.eoe, want.err,
                         got.kind, got.value, got.eoe, got.err));
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  i2p_tok_if #(.VALUE_WIDTH(VALUE_WIDTH)) tok_ch ();
  i2p_res_if #(.VALUE_WIDTH(VALUE_WIDTH)) res_ch ();

  infix_to_postfix_converter_core #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_tok (tok_ch),
    .out_res(res_ch)
  );

  postfix_board board = new();
  token_t       token_q[$];
  int           sent_items = 0;
  bit           calm = 1'b0;
  int           cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // End the run if it stalls
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[infix_to_postfix_converter_core] ERROR");
    $finish;
  end

  function automatic token_t make_token(logic [2:0] k, logic [VALUE_WIDTH-1:0] v = '0,
                                        logic l = 1'b0);
    token_t t;
    t.kind  = k;
    t.value = (k == KIND_OPERAND) ? v : VALUE_WIDTH'($urandom());
    t.last  = l;
    return t;
  endfunction

  // Offer one token, with random gaps, and hold it until the transfer
  task automatic send_token(token_t t);
    calm = (sent_items >= CALM_FROM && sent_items < CALM_TO);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      tok_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tok_ch.valid         <= 1'b1;
    tok_ch.kind          <= t.kind;
    tok_ch.operand_value <= t.value;
    tok_ch.last          <= t.last;
    @(posedge clk);
    while (!tok_ch.ready) @(posedge clk);
    board.note_token(t);
    if (t.kind != KIND_UNDEF || t.last) sent_items++;
  endtask

  task automatic send_queued();
    while (token_q.size() != 0) send_token(token_q.pop_front());
  endtask

  // Edge cases: ignored codes, stray close, all operators, value extremes, overflow
  task automatic queue_directed();
    token_q.push_back(make_token(KIND_UNDEF));
    token_q.push_back(make_token(KIND_UNDEF, '0, 1'b1));
    token_q.push_back(make_token(KIND_CLOSE));
    token_q.push_back(make_token(KIND_OPERAND, '0));
    token_q.push_back(make_token(KIND_TIMES));
    token_q.push_back(make_token(KIND_OPERAND, '1));
    token_q.push_back(make_token(KIND_MINUS));
    token_q.push_back(make_token(KIND_OPERAND, VALUE_WIDTH'($urandom())));
    token_q.push_back(make_token(KIND_DIVIDE));
    token_q.push_back(make_token(KIND_OPERAND, VALUE_WIDTH'($urandom())));
    token_q.push_back(make_token(KIND_PLUS));
    token_q.push_back(make_token(KIND_OPERAND, VALUE_WIDTH'($urandom()), 1'b1));
    repeat (STACK_DEPTH + 1) token_q.push_back(make_token(KIND_OPEN));
    token_q.push_back(make_token(KIND_PLUS));
    token_q.push_back(make_token(KIND_OPERAND, VALUE_WIDTH'($urandom()), 1'b1));
  endtask

  // Build a well-formed expression with random nesting; some are broken on purpose
  task automatic queue_expression();
    int  open_n;
    int  terms;
    int  want_terms;
    int  max_nest;
    bit  deep;
    deep       = ($urandom_range(9) == 0);
    max_nest   = deep ? 10 : $urandom_range(3);
    want_terms = deep ? 12 : $urandom_range(1, 6);
    open_n     = 0;
    terms      = 0;
    do begin
      while (open_n < max_nest && $urandom_range(99) < 30) begin
        token_q.push_back(make_token(KIND_OPEN));
        open_n++;
      end
      token_q.push_back(make_token(KIND_OPERAND, VALUE_WIDTH'($urandom())));
      terms++;
      while (open_n > 0 && $urandom_range(99) < 35) begin
        token_q.push_back(make_token(KIND_CLOSE));
        open_n--;
      end
      if (terms < want_terms)
        token_q.push_back(make_token(3'($urandom_range(KIND_PLUS, KIND_DIVIDE))));
    end while (terms < want_terms);
    while (open_n > 0) begin
      token_q.push_back(make_token(KIND_CLOSE));
      open_n--;
    end
    token_q[token_q.size()-1].last = 1'b1;
    // Drop a token or the end mark now and then
    if ($urandom_range(99) < 10)
      token_q.delete($urandom_range(token_q.size() - 1));
    else if ($urandom_range(99) < 5)
      token_q[token_q.size()-1].last = 1'b0;
  endtask

  task automatic queue_noise();
    token_t t;
    repeat ($urandom_range(1, 4)) begin
      t.kind  = 3'($urandom_range(7));
      t.value = VALUE_WIDTH'($urandom());
      t.last  = ($urandom_range(7) == 0);
      token_q.push_back(t);
    end
  endtask

  // Result side: random stalls, one long hold-off, check every transfer
  initial begin
    int       hold_left;
    bit       held_off;
    postfix_t got;
    hold_left = 0;
    held_off  = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        got.kind  = res_ch.out_kind;
        got.value = res_ch.out_value;
        got.eoe   = res_ch.end_of_expression;
        got.err   = err_t'(res_ch.error_code);
        board.check_result(got);
      end
      if (!held_off && sent_items >= HOLD_AT) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Reset, directed tokens, random expressions, drain and verdict
  initial begin
    rst_n                <= 1'b0;
    tok_ch.valid         <= 1'b0;
    tok_ch.kind          <= KIND_OPERAND;
    tok_ch.operand_value <= '0;
    tok_ch.last          <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed();
    send_queued();
    while (sent_items < ITEM_TARGET) begin
      if ($urandom_range(99) < 85) queue_expression();
      else queue_noise();
      send_queued();
    end
    tok_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("[infix_to_postfix_converter_core] OK");
    end else begin
      $display("[infix_to_postfix_converter_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/i2p_pkg.sv
src/i2p_tok_if.sv
src/i2p_res_if.sv
src/i2p_ctrl.sv
src/i2p_datapath.sv
src/infix_to_postfix_converter_core.sv
tb/infix_to_postfix_converter_core_test.sv
